FILE: sv/rit_pkg.sv
// Shared types and constants for the refcounted id table.
package rit_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W  = 32;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [2:0]        func_t;
    typedef logic [1:0]        status_t;

    localparam func_t FN_READ  = 3'd0;
    localparam func_t FN_ADD   = 3'd1;
    localparam func_t FN_SUB   = 3'd2;
    localparam func_t FN_ALLOC = 3'd3;
    localparam func_t FN_CLAIM = 3'd4;

    localparam status_t STS_OK    = 2'd0;
    localparam status_t STS_FULL  = 2'd1;
    localparam status_t STS_UNDER = 2'd2;
    localparam status_t STS_OVER  = 2'd3;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_EXEC
    } ctrl_state_t;

    // Search token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic  vld;
        logic  hit;
        idx_t  hit_idx;
        logic  hit_alloc;
        data_t hit_count;
        logic  emp_hit;
        idx_t  emp_idx;
        logic  fre_hit;
        idx_t  fre_idx;
        data_t fre_id;
    } scan_t;

    // Table update broadcast to all cells.
    typedef struct packed {
        logic  en;
        idx_t  idx;
        data_t id;
        logic  alloc;
        logic  wr_cnt;
        data_t cnt;
    } commit_t;

endpackage

FILE: sv/refcounted_id_table_with_free_pool.sv
// Refcounted id table top level: a chain of ENTRIES slot cells and a sequencer.
// The search token crosses the slot cells, each of which registers it; the sequencer
// captures it at the tail, then decides and commits the update in its EXEC state. Requests
// are taken one at a time: in_stall holds off the next beat until the result is loaded, but
// the next beat is taken while a result still waits at the output register.
// Reset: asynchronous, active low; id 0 is allocated with count 0, all other slots empty.
module refcounted_id_table_with_free_pool (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rit_pkg::func_t   func,
    input  rit_pkg::data_t   lookup_id,
    input  rit_pkg::data_t   amount,
    output logic             out_valid,
    input  logic             out_stall,
    output rit_pkg::data_t   value,
    output logic             present,
    output logic             found,
    output rit_pkg::status_t status
);
    import rit_pkg::*;

    scan_t   chain [ENTRIES+1];
    data_t   req_id;
    commit_t commit;

    rit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .lookup_id (lookup_id),
        .amount    (amount),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .present   (present),
        .found     (found),
        .status    (status),
        .req_id    (req_id),
        .head      (chain[0]),
        .tail      (chain[ENTRIES]),
        .commit    (commit)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rit_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (idx_t'(i)),
            .req_id   (req_id),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .commit   (commit)
        );
    end

endmodule

FILE: sv/rit_cell.sv
// One table slot: holds its entry and merges it into the passing search token.
module rit_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  rit_pkg::idx_t   slot_idx,
    input  rit_pkg::data_t  req_id,
    input  rit_pkg::scan_t  scan_in,
    output rit_pkg::scan_t  scan_out,
    input  rit_pkg::commit_t commit
);
    import rit_pkg::*;

    logic  valid_reg, valid_next;
    logic  alloc_reg, alloc_next;
    data_t id_reg, id_next;
    data_t count_reg, count_next;
    scan_t scan_reg, scan_next;
    logic  match;
    logic  sel;

    assign match = valid_reg && (id_reg == req_id);
    assign sel   = commit.en && (commit.idx == slot_idx);

    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.vld)
        begin
            if (match)
            begin
                scan_next.hit       = 1'b1;
                scan_next.hit_idx   = slot_idx;
                scan_next.hit_alloc = alloc_reg;
                scan_next.hit_count = count_reg;
            end
            if (!scan_in.emp_hit && !valid_reg)
            begin
                scan_next.emp_hit = 1'b1;
                scan_next.emp_idx = slot_idx;
            end
            if (!scan_in.fre_hit && valid_reg && !alloc_reg)
            begin
                scan_next.fre_hit = 1'b1;
                scan_next.fre_idx = slot_idx;
                scan_next.fre_id  = id_reg;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        alloc_next = alloc_reg;
        id_next    = id_reg;
        count_next = count_reg;
        if (sel)
        begin
            valid_next = 1'b1;
            alloc_next = commit.alloc;
            id_next    = commit.id;
            if (commit.wr_cnt)
            begin
                count_next = commit.cnt;
            end
        end
    end

    // Slot 0 comes out of reset holding id 0, allocated, count 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= (slot_idx == '0);
            alloc_reg <= (slot_idx == '0);
            id_reg    <= '0;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            alloc_reg <= alloc_next;
            id_reg    <= id_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

FILE: sv/rit_ctrl.sv
// Request sequencer: launches the search, decides the update and holds the result.
module rit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rit_pkg::func_t    func,
    input  rit_pkg::data_t    lookup_id,
    input  rit_pkg::data_t    amount,
    output logic              out_valid,
    input  logic              out_stall,
    output rit_pkg::data_t    value,
    output logic              present,
    output logic              found,
    output rit_pkg::status_t  status,
    output rit_pkg::data_t    req_id,
    output rit_pkg::scan_t    head,
    input  rit_pkg::scan_t    tail,
    output rit_pkg::commit_t  commit
);
    import rit_pkg::*;

    ctrl_state_t state_reg, state_next;
    func_t       func_reg, func_next;
    data_t       id_reg, id_next;
    data_t       amt_reg, amt_next;
    logic        head_reg, head_next;
    scan_t       tail_reg, tail_next;
    logic        out_valid_reg, out_valid_next;
    data_t       value_reg, value_next;
    logic        present_reg, present_next;
    logic        found_reg, found_next;
    status_t     status_reg, status_next;

    logic        accept;
    logic        out_load;
    func_t       fn;
    logic        pres;
    logic        room;
    idx_t        tgt;
    data_t       cur;
    logic [DATA_W:0] sum;
    data_t       diff;
    data_t       res_value;
    logic        res_present;
    logic        res_found;
    status_t     res_status;
    commit_t     res_commit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (in_valid) state_next = CS_SCAN;
            CS_SCAN: if (tail.vld) state_next = CS_EXEC;
            CS_EXEC: if (!out_valid_reg || !out_stall) state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            CS_IDLE: in_stall = 1'b0;
            CS_SCAN: in_stall = 1'b1;
            CS_EXEC: out_load = !out_valid_reg || !out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    // Decide result and table update from the finished search
    always_comb
    begin
        fn = func_reg;
        if ((fn == FN_ADD || fn == FN_SUB) && amt_reg == '0)
        begin
            fn = FN_READ;
        end
        pres = tail_reg.hit && tail_reg.hit_alloc;
        room = tail_reg.hit || tail_reg.emp_hit;
        tgt  = tail_reg.hit ? tail_reg.hit_idx : tail_reg.emp_idx;
        cur  = tail_reg.hit ? tail_reg.hit_count : '0;
        sum  = {1'b0, cur} + {1'b0, amt_reg};
        diff = cur - amt_reg;

        res_value      = '0;
        res_present    = pres;
        res_found      = 1'b0;
        res_status     = STS_OK;
        res_commit     = '0;
        res_commit.idx = tgt;
        res_commit.id  = id_reg;

        unique case (fn)
            FN_READ:
            begin
                res_value = pres ? tail_reg.hit_count : '0;
            end
            FN_ADD:
            begin
                if (!room)
                begin
                    res_status = STS_FULL;
                end
                else if (sum[DATA_W])
                begin
                    res_status = STS_OVER;
                    res_value  = cur;
                end
                else
                begin
                    res_value         = cur;
                    res_commit.en     = 1'b1;
                    res_commit.alloc  = 1'b1;
                    res_commit.wr_cnt = 1'b1;
                    res_commit.cnt    = sum[DATA_W-1:0];
                end
            end
            FN_SUB:
            begin
                if (!room)
                begin
                    res_status = STS_FULL;
                end
                else if (amt_reg > cur)
                begin
                    res_status = STS_UNDER;
                    res_value  = cur;
                end
                else
                begin
                    // A count that reaches zero goes back to the free pool.
                    res_value         = cur;
                    res_commit.en     = 1'b1;
                    res_commit.alloc  = (diff != '0);
                    res_commit.wr_cnt = 1'b1;
                    res_commit.cnt    = diff;
                end
            end
            FN_ALLOC:
            begin
                if (tail_reg.hit)
                begin
                    res_value        = tail_reg.hit_count;
                    res_commit.en    = 1'b1;
                    res_commit.alloc = 1'b1;
                end
                else if (tail_reg.emp_hit)
                begin
                    res_commit.en     = 1'b1;
                    res_commit.alloc  = 1'b1;
                    res_commit.wr_cnt = 1'b1;
                    res_commit.cnt    = '0;
                end
                else
                begin
                    res_status = STS_FULL;
                end
            end
            FN_CLAIM:
            begin
                res_present = 1'b0;
                if (tail_reg.fre_hit)
                begin
                    res_value        = tail_reg.fre_id;
                    res_found        = 1'b1;
                    res_commit.en    = 1'b1;
                    res_commit.idx   = tail_reg.fre_idx;
                    res_commit.id    = tail_reg.fre_id;
                    res_commit.alloc = 1'b1;
                end
            end
            default:
            begin
                res_present = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        func_next      = func_reg;
        id_next        = id_reg;
        amt_next       = amt_reg;
        tail_next      = tail_reg;
        head_next      = accept;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        present_next   = present_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        if (accept)
        begin
            func_next = func;
            id_next   = lookup_id;
            amt_next  = amount;
        end
        if (state_reg == CS_SCAN && tail.vld)
        begin
            tail_next = tail;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = res_value;
            present_next   = res_present;
            found_next     = res_found;
            status_next    = res_status;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            head_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        id_reg      <= id_next;
        amt_reg     <= amt_next;
        tail_reg    <= tail_next;
        value_reg   <= value_next;
        present_reg <= present_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        head     = '0;
        head.vld = head_reg;
    end

    assign req_id     = id_reg;
    assign commit     = '{en: res_commit.en && out_load, idx: res_commit.idx,
                          id: res_commit.id, alloc: res_commit.alloc,
                          wr_cnt: res_commit.wr_cnt, cnt: res_commit.cnt};
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign present    = present_reg;
    assign found      = found_reg;
    assign status     = status_reg;

endmodule
